>>> sv/dhoat_pkg.sv
// Shared types and constants for the double-hashing open-address table.
package dhoat_pkg;

    localparam int LOG_SLOTS_DEF  = 10;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ALPHA_NUM_W = 17;
    localparam int ALPHA_DEN_W = 5;

    localparam logic [63:0] PRIME_A = 64'hdad8_6dbe_4c70_8969;
    localparam logic [63:0] PRIME_B = 64'hbd8f_5cb7_33a5_d047;

    // Request commands.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_MISS     = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_OVER     = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // Slot tags.
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ALPHA_NUM     = 1'b0;
    localparam logic REG_ALPHA_LOG_DEN = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_RB_CLEAR,
        S_RB_RD,
        S_RB_CHK,
        S_RESULT
    } state_t;

endpackage

>>> sv/double_hash_open_address_table.sv
// Top level of the double-hashing open-address key-value table.
//
// Requests enter on the s_ channel (command, key, value) with valid/ready;
// each request gives exactly one result on the m_ channel (found, value_out,
// status). Configuration registers alpha_num (index 0) and alpha_log_den
// (index 1) are written through cfg_we/cfg_idx/cfg_wdata at any time.
// One request is worked on at a time. A request is hashed on
// a shared 32x32 multiplier (two 64-bit products, three partial products
// each), then probes the slot memory (read, then compare, for each probe),
// and then posts the result. A CMD_NONE request answers a miss without
// hashing. The next request can be taken in the cycle after a result is
// posted. An insert that triggers a rebuild also clears the tags of the
// other bank, then reads each source slot and rehashes and places each
// live entry found there into that bank.
// After reset the slot tags of both banks are cleared, one entry a cycle;
// s_ready stays low meanwhile. A result waits in the output register while
// m_ready is low; the next request is taken meanwhile, but its result waits
// until the slot frees.
module double_hash_open_address_table #(
    parameter int LOG_SLOTS  = dhoat_pkg::LOG_SLOTS_DEF,
    parameter int VALUE_BITS = dhoat_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [16:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_key,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_value_out,
    output logic [2:0]  m_status
);

    localparam int SLOTS = 1 << LOG_SLOTS;
    localparam int DEPTH = 2 * SLOTS;
    localparam int CW    = LOG_SLOTS + 1;
    localparam int LW    = dhoat_pkg::ALPHA_NUM_W + LOG_SLOTS;
    localparam logic [CW-1:0] SLOT_LAST = CW'(SLOTS - 1);
    localparam logic [CW-1:0] ALL_PROBES = CW'(SLOTS);

    // Slot memories, both banks; the bank is the top address bit.
    logic [1:0]            tag_mem [DEPTH];
    logic [63:0]           key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];

    dhoat_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [2:0]                     hstep_reg, hstep_next;
    logic [63:0]                    prod_reg, prod_next;
    logic [31:0]                    acc_a_reg, acc_a_next;
    logic [31:0]                    acc_b_reg, acc_b_next;
    logic [1:0]                     cmd_reg, cmd_next;
    logic [63:0]                    key_reg, key_next;
    logic [VALUE_BITS-1:0]          val_reg, val_next;
    logic [LOG_SLOTS-1:0]           ix_reg, ix_next;
    logic [LOG_SLOTS-1:0]           stride_reg, stride_next;
    logic [CW-1:0]                  probes_reg, probes_next;
    logic                           rb_reg, rb_next;
    logic                           bank_reg, bank_next;
    logic [LOG_SLOTS-1:0]           live_reg, live_next;
    logic [LOG_SLOTS-1:0]           tomb_reg, tomb_next;
    logic [CW-1:0]                  maxp_reg, maxp_next;
    logic [dhoat_pkg::ALPHA_NUM_W-1:0] alpha_num_reg;
    logic [dhoat_pkg::ALPHA_DEN_W-1:0] alpha_den_reg;
    logic                           res_found_reg, res_found_next;
    logic [31:0]                    res_vout_reg, res_vout_next;
    logic [2:0]                     res_status_reg, res_status_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_found_reg, m_found_next;
    logic [31:0]                    m_vout_reg, m_vout_next;
    logic [2:0]                     m_status_reg, m_status_next;

    // Memory ports.
    logic                  tag_we, data_we;
    logic [CW-1:0]         wr_addr, rd_addr;
    logic [1:0]            tag_wd;
    logic [63:0]           key_wd;
    logic [VALUE_BITS-1:0] val_wd;
    logic [1:0]            tag_rd;
    logic [63:0]           key_rd;
    logic [VALUE_BITS-1:0] val_rd;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] hash_term, hash_b;
    logic [LOG_SLOTS-1:0] home_ix, stride_raw, stride_odd;

    logic [CW-1:0]        probe_addr;
    logic                 is_empty, is_hit, last_src, out_free;
    logic [CW-1:0]        used, used_new, live_inc, limit, maxp_upd;
    logic [LW-1:0]        lim_wide;
    logic                 table_full, over_limit, want_rebuild;

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (hstep_reg)
            3'd0: begin mul_a = key_reg[31:0];  mul_b = dhoat_pkg::PRIME_A[31:0];  end
            3'd1: begin mul_a = key_reg[31:0];  mul_b = dhoat_pkg::PRIME_A[63:32]; end
            3'd2: begin mul_a = key_reg[63:32]; mul_b = dhoat_pkg::PRIME_A[31:0];  end
            3'd3: begin mul_a = key_reg[31:0];  mul_b = dhoat_pkg::PRIME_B[31:0];  end
            3'd4: begin mul_a = key_reg[31:0];  mul_b = dhoat_pkg::PRIME_B[63:32]; end
            3'd5: begin mul_a = key_reg[63:32]; mul_b = dhoat_pkg::PRIME_B[31:0];  end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end

    // The full low-by-low product feeds its upper half into the top word;
    // the cross products only matter through their lower halves.
    assign hash_term  = (hstep_reg == 3'd1 || hstep_reg == 3'd4) ? prod_reg[63:32]
                                                                  : prod_reg[31:0];
    assign hash_b     = acc_b_reg + hash_term;
    assign home_ix    = acc_a_reg[31 -: LOG_SLOTS];
    assign stride_raw = hash_b[31 -: LOG_SLOTS];
    assign stride_odd = stride_raw[0] ? stride_raw :
                        (stride_raw == '0) ? LOG_SLOTS'(1) : stride_raw - LOG_SLOTS'(1);

    assign probe_addr = {(rb_reg ? ~bank_reg : bank_reg), ix_reg};
    assign rd_addr    = (state_reg == dhoat_pkg::S_RB_RD)
                        ? {bank_reg, cnt_reg[LOG_SLOTS-1:0]} : probe_addr;

    assign is_empty = (tag_rd == dhoat_pkg::TAG_EMPTY);
    assign is_hit   = (tag_rd == dhoat_pkg::TAG_LIVE) && (key_rd == key_reg);
    assign last_src = &cnt_reg[LOG_SLOTS-1:0];
    assign out_free = !m_valid_reg || m_ready;

    assign used     = {1'b0, live_reg} + {1'b0, tomb_reg};
    assign used_new = used + CW'(1);
    assign live_inc = {1'b0, live_reg} + CW'(1);
    assign lim_wide = {alpha_num_reg, {LOG_SLOTS{1'b0}}} >> alpha_den_reg;
    assign limit    = (lim_wide > LW'(SLOTS - 1)) ? SLOT_LAST : lim_wide[CW-1:0];
    assign maxp_upd = (probes_reg > maxp_reg) ? probes_reg : maxp_reg;

    assign table_full   = (used >= SLOT_LAST);
    assign over_limit   = (used_new > limit);
    assign want_rebuild = over_limit && (live_inc < {1'b0, tomb_reg});

    assign s_ready     = (state_reg == dhoat_pkg::S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_value_out = m_vout_reg;
    assign m_status    = m_status_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dhoat_pkg::S_INIT: begin
                if (&cnt_reg) state_next = dhoat_pkg::S_IDLE;
            end
            dhoat_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_command == dhoat_pkg::CMD_NONE)
                                 ? dhoat_pkg::S_RESULT : dhoat_pkg::S_HASH;
                end
            end
            dhoat_pkg::S_HASH: begin
                if (hstep_reg == 3'd6) state_next = dhoat_pkg::S_PROBE_RD;
            end
            dhoat_pkg::S_PROBE_RD: begin
                state_next = dhoat_pkg::S_PROBE_CHK;
            end
            dhoat_pkg::S_PROBE_CHK: begin
                if (rb_reg) begin
                    if (!is_empty) state_next = dhoat_pkg::S_PROBE_RD;
                    else if (last_src) state_next = dhoat_pkg::S_RESULT;
                    else state_next = dhoat_pkg::S_RB_RD;
                end else if (cmd_reg == dhoat_pkg::CMD_INSERT) begin
                    if (is_empty && !table_full && want_rebuild)
                        state_next = dhoat_pkg::S_RB_CLEAR;
                    else if (is_empty || is_hit || probes_reg == ALL_PROBES)
                        state_next = dhoat_pkg::S_RESULT;
                    else
                        state_next = dhoat_pkg::S_PROBE_RD;
                end else begin
                    if (is_empty || is_hit || probes_reg >= maxp_reg)
                        state_next = dhoat_pkg::S_RESULT;
                    else
                        state_next = dhoat_pkg::S_PROBE_RD;
                end
            end
            dhoat_pkg::S_RB_CLEAR: begin
                if (last_src) state_next = dhoat_pkg::S_RB_RD;
            end
            dhoat_pkg::S_RB_RD: begin
                state_next = dhoat_pkg::S_RB_CHK;
            end
            dhoat_pkg::S_RB_CHK: begin
                if (tag_rd == dhoat_pkg::TAG_LIVE) state_next = dhoat_pkg::S_HASH;
                else if (last_src) state_next = dhoat_pkg::S_RESULT;
                else state_next = dhoat_pkg::S_RB_RD;
            end
            dhoat_pkg::S_RESULT: begin
                if (out_free) state_next = dhoat_pkg::S_IDLE;
            end
            default: state_next = dhoat_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        cnt_next        = cnt_reg;
        hstep_next      = hstep_reg;
        prod_next       = prod_reg;
        acc_a_next      = acc_a_reg;
        acc_b_next      = acc_b_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        ix_next         = ix_reg;
        stride_next     = stride_reg;
        probes_next     = probes_reg;
        rb_next         = rb_reg;
        bank_next       = bank_reg;
        live_next       = live_reg;
        tomb_next       = tomb_reg;
        maxp_next       = maxp_reg;
        res_found_next  = res_found_reg;
        res_vout_next   = res_vout_reg;
        res_status_next = res_status_reg;
        tag_we          = 1'b0;
        data_we         = 1'b0;
        wr_addr         = probe_addr;
        tag_wd          = dhoat_pkg::TAG_LIVE;
        key_wd          = key_reg;
        val_wd          = val_reg;

        unique case (state_reg)
            dhoat_pkg::S_INIT: begin
                tag_we   = 1'b1;
                tag_wd   = dhoat_pkg::TAG_EMPTY;
                wr_addr  = cnt_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            dhoat_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_command;
                    key_next        = s_key;
                    val_next        = VALUE_BITS'(s_value);
                    rb_next         = 1'b0;
                    hstep_next      = 3'd0;
                    res_found_next  = 1'b0;
                    res_vout_next   = 32'd0;
                    res_status_next = dhoat_pkg::ST_MISS;
                end
            end
            dhoat_pkg::S_HASH: begin
                prod_next  = mul_p;
                hstep_next = hstep_reg + 3'd1;
                if (hstep_reg == 3'd0) begin
                    acc_a_next = 32'd0;
                    acc_b_next = 32'd0;
                end else if (hstep_reg <= 3'd3) begin
                    acc_a_next = acc_a_reg + hash_term;
                end else begin
                    acc_b_next = hash_b;
                end
                if (hstep_reg == 3'd6) begin
                    ix_next     = home_ix;
                    stride_next = stride_odd;
                    probes_next = CW'(1);
                end
            end
            dhoat_pkg::S_PROBE_RD: begin
            end
            dhoat_pkg::S_PROBE_CHK: begin
                if (rb_reg) begin
                    if (is_empty) begin
                        tag_we    = 1'b1;
                        data_we   = 1'b1;
                        maxp_next = maxp_upd;
                        cnt_next  = cnt_reg + CW'(1);
                        if (last_src) begin
                            bank_next = ~bank_reg;
                            rb_next   = 1'b0;
                        end
                    end else begin
                        ix_next     = ix_reg + stride_reg;
                        probes_next = probes_reg + CW'(1);
                    end
                end else if (cmd_reg == dhoat_pkg::CMD_INSERT) begin
                    if (is_hit) begin
                        data_we         = 1'b1;
                        key_wd          = key_rd;
                        maxp_next       = maxp_upd;
                        res_found_next  = 1'b1;
                        res_status_next = dhoat_pkg::ST_UPDATED;
                    end else if (is_empty) begin
                        if (table_full) begin
                            res_status_next = dhoat_pkg::ST_FULL;
                        end else begin
                            tag_we    = 1'b1;
                            data_we   = 1'b1;
                            maxp_next = maxp_upd;
                            live_next = live_inc[LOG_SLOTS-1:0];
                            if (want_rebuild) begin
                                res_status_next = dhoat_pkg::ST_INSERTED;
                                cnt_next        = '0;
                            end else if (over_limit) begin
                                res_status_next = dhoat_pkg::ST_OVER;
                            end else begin
                                res_status_next = dhoat_pkg::ST_INSERTED;
                            end
                        end
                    end else if (probes_reg == ALL_PROBES) begin
                        res_status_next = dhoat_pkg::ST_FULL;
                    end else begin
                        ix_next     = ix_reg + stride_reg;
                        probes_next = probes_reg + CW'(1);
                    end
                end else begin
                    if (is_hit) begin
                        res_found_next = 1'b1;
                        res_vout_next  = 32'(val_rd);
                        if (cmd_reg == dhoat_pkg::CMD_REMOVE) begin
                            res_status_next = dhoat_pkg::ST_REMOVED;
                            tag_we          = 1'b1;
                            tag_wd          = dhoat_pkg::TAG_TOMB;
                            live_next       = live_reg - LOG_SLOTS'(1);
                            tomb_next       = tomb_reg + LOG_SLOTS'(1);
                        end else begin
                            res_status_next = dhoat_pkg::ST_HIT;
                        end
                    end else if (!is_empty && probes_reg < maxp_reg) begin
                        ix_next     = ix_reg + stride_reg;
                        probes_next = probes_reg + CW'(1);
                    end
                end
            end
            dhoat_pkg::S_RB_CLEAR: begin
                tag_we   = 1'b1;
                tag_wd   = dhoat_pkg::TAG_EMPTY;
                wr_addr  = {~bank_reg, cnt_reg[LOG_SLOTS-1:0]};
                cnt_next = cnt_reg + CW'(1);
                if (last_src) begin
                    cnt_next  = '0;
                    maxp_next = CW'(1);
                    tomb_next = '0;
                    rb_next   = 1'b1;
                end
            end
            dhoat_pkg::S_RB_RD: begin
            end
            dhoat_pkg::S_RB_CHK: begin
                if (tag_rd == dhoat_pkg::TAG_LIVE) begin
                    key_next   = key_rd;
                    val_next   = val_rd;
                    hstep_next = 3'd0;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    if (last_src) begin
                        bank_next = ~bank_reg;
                        rb_next   = 1'b0;
                    end
                end
            end
            dhoat_pkg::S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_found_next  = m_found_reg;
        m_vout_next   = m_vout_reg;
        m_status_next = m_status_reg;
        if (state_reg == dhoat_pkg::S_RESULT && out_free) begin
            m_valid_next  = 1'b1;
            m_found_next  = res_found_reg;
            m_vout_next   = res_vout_reg;
            m_status_next = res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_we) tag_mem[wr_addr] <= tag_wd;
        if (data_we) begin
            key_mem[wr_addr] <= key_wd;
            val_mem[wr_addr] <= val_wd;
        end
        tag_rd <= tag_mem[rd_addr];
        key_rd <= key_mem[rd_addr];
        val_rd <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dhoat_pkg::S_INIT;
            cnt_reg       <= '0;
            rb_reg        <= 1'b0;
            bank_reg      <= 1'b0;
            live_reg      <= '0;
            tomb_reg      <= '0;
            maxp_reg      <= CW'(1);
            alpha_num_reg <= dhoat_pkg::ALPHA_NUM_W'(1);
            alpha_den_reg <= dhoat_pkg::ALPHA_DEN_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rb_reg      <= rb_next;
            bank_reg    <= bank_next;
            live_reg    <= live_next;
            tomb_reg    <= tomb_next;
            maxp_reg    <= maxp_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    dhoat_pkg::REG_ALPHA_NUM:     alpha_num_reg <= cfg_wdata;
                    dhoat_pkg::REG_ALPHA_LOG_DEN:
                        alpha_den_reg <= cfg_wdata[dhoat_pkg::ALPHA_DEN_W-1:0];
                    default: alpha_num_reg <= alpha_num_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        hstep_reg      <= hstep_next;
        prod_reg       <= prod_next;
        acc_a_reg      <= acc_a_next;
        acc_b_reg      <= acc_b_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        ix_reg         <= ix_next;
        stride_reg     <= stride_next;
        probes_reg     <= probes_next;
        res_found_reg  <= res_found_next;
        res_vout_reg   <= res_vout_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_vout_reg     <= m_vout_next;
        m_status_reg   <= m_status_next;
    end

`ifndef SYNTHESIS
    // Live entries and tombstones together never fill the last free slot.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, live_reg} + {1'b0, tomb_reg}) <= SLOT_LAST)
        else $error("occupancy exceeds slots - 1");

    // The recorded probe bound stays between one and the slot count.
    a_maxp: assert property (@(posedge aclk) disable iff (!aresetn)
        maxp_reg != '0 && maxp_reg <= ALL_PROBES)
        else $error("max probe count out of range");

    // An accepted request always leaves the idle state.
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != dhoat_pkg::S_IDLE)
        else $error("request accepted without starting work");

    // A result is only posted with a defined status code.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 3'd7)
        else $error("undefined status on result");
`endif

endmodule
